// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and masked during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequent holds at every edge where the antecedent holds.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_AT(lbl, (ante) |-> (cons), msg)

`endif

// File: hw/rtl/plpd_pkg.sv
// ----------------------------------------------------------------------------
// plpd_pkg
// Shared constants and types of the preamble/length/postamble deframer.
// ----------------------------------------------------------------------------
package plpd_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int BYTE_W          = 8;
  localparam int INDEX_W         = 6;
  localparam int COUNT_W         = 16;
  localparam int CFG_ADDR_W      = 2;
  localparam int OUT_TDATA_W     = 40;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FIRST_PRE   = 2'd0,
    REG_SECOND_PRE  = 2'd1,
    REG_FIRST_POST  = 2'd2,
    REG_SECOND_POST = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  length;
    logic [COUNT_W-1:0] count;
    logic               bank;
  } frame_desc_t;

  typedef struct packed {
    logic clr;
    logic clr_bank;
    logic active;
  } back_stat_t;

endpackage

// File: hw/rtl/plpd_ram.sv
// ----------------------------------------------------------------------------
// plpd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module plpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/plpd_queue.sv
// ----------------------------------------------------------------------------
// plpd_queue
// Two-entry queue of completed frame descriptors between parser and reader.
// ----------------------------------------------------------------------------
module plpd_queue #(
  parameter int WIDTH = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty,
  output logic [1:0]       count
);

  logic [WIDTH-1:0] slot [2];
  logic             wptr;
  logic             rptr;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/plpd_front.sv
// ----------------------------------------------------------------------------
// plpd_front
// Byte parser: tracks the frame phase, writes each beat that fits in the
// frame to the buffer bank in use and posts a descriptor when a frame completes.
// ----------------------------------------------------------------------------
module plpd_front #(
  parameter int FRAME_BYTES = plpd_pkg::FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [plpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [plpd_pkg::BYTE_W-1:0]         cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [plpd_pkg::BYTE_W-1:0]         s_tdata,
  input  logic                                q_full,
  output logic                                q_push,
  output plpd_pkg::frame_desc_t               q_desc,
  output logic [$clog2(FRAME_BYTES)-1:0]      q_last_idx,
  output logic                                ram_we,
  output logic [$clog2(FRAME_BYTES):0]        ram_waddr,
  output logic [plpd_pkg::BYTE_W-1:0]         ram_wdata,
  input  plpd_pkg::back_stat_t                bstat,
  output logic [1:0]                          busy
);

  import plpd_pkg::*;

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int WPW = $clog2(FRAME_BYTES + 1);
  localparam int CW  = ((WPW > BYTE_W) ? WPW : BYTE_W) + 2;

  typedef enum logic [5:0] {
    PH_PRE1  = 6'b000001,
    PH_PRE2  = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_DATA  = 6'b001000,
    PH_POST1 = 6'b010000,
    PH_POST2 = 6'b100000
  } phase_t;

  logic [BYTE_W-1:0]  first_pre;
  logic [BYTE_W-1:0]  second_pre;
  logic [BYTE_W-1:0]  first_post;
  logic [BYTE_W-1:0]  second_post;

  phase_t             phase;
  phase_t             phase_next;
  logic [WPW-1:0]     wp;
  logic [WPW-1:0]     wp_next;
  logic [BYTE_W-1:0]  hl;
  logic [BYTE_W-1:0]  hl_next;
  logic [BYTE_W-1:0]  prev;
  logic [COUNT_W-1:0] cnt;
  logic               bank;
  logic [1:0]         busy_next;

  logic [BYTE_W-1:0]  b;
  logic               acc;
  logic               st_en;
  logic [WPW-1:0]     st_pos;
  logic               done;
  logic               resync;
  logic               len_reached;

  assign b        = s_tdata;
  assign s_tready = !busy[bank] && !q_full;
  assign acc      = s_tvalid && s_tready;

  // data ends once position + 1 >= length - 2, compared unsigned as position + 3 >= length
  assign len_reached = (CW'(wp) + CW'(3)) >= CW'(hl);

  always_comb begin
    phase_next = phase;
    wp_next    = wp;
    hl_next    = hl;
    st_en      = 1'b0;
    st_pos     = wp;
    done       = 1'b0;
    resync     = 1'b0;
    unique case (phase)
      PH_PRE2: begin
        if (b == second_pre) begin
          st_en      = 1'b1;
          st_pos     = WPW'(1);
          wp_next    = WPW'(2);
          phase_next = PH_LEN;
        end else begin
          resync = 1'b1;
        end
      end
      PH_LEN: begin
        hl_next    = b;
        st_en      = 1'b1;
        wp_next    = wp + WPW'(1);
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        if (wp >= WPW'(FRAME_BYTES - 1)) begin
          resync = 1'b1;
        end else if ((b == second_pre) && (prev == first_pre)) begin
          st_en      = 1'b1;
          st_pos     = WPW'(1);
          wp_next    = WPW'(2);
          phase_next = PH_LEN;
        end else begin
          st_en   = 1'b1;
          wp_next = wp + WPW'(1);
          if (len_reached) begin
            phase_next = PH_POST1;
          end
        end
      end
      PH_POST1: begin
        if (b == first_post) begin
          st_en      = 1'b1;
          wp_next    = wp + WPW'(1);
          phase_next = PH_POST2;
        end else begin
          resync = 1'b1;
        end
      end
      PH_POST2: begin
        if (b == second_post) begin
          st_en      = (wp < WPW'(FRAME_BYTES));
          phase_next = PH_PRE1;
          done       = 1'b1;
        end else begin
          resync = 1'b1;
        end
      end
      PH_PRE1: resync = 1'b1;
      default: resync = 1'b1;
    endcase
    if (resync) begin
      wp_next    = '0;
      st_en      = 1'b1;
      st_pos     = '0;
      phase_next = (b == first_pre) ? PH_PRE2 : PH_PRE1;
    end
  end

  assign ram_we     = acc && st_en;
  assign ram_waddr  = {bank, st_pos[AW-1:0]};
  assign ram_wdata  = b;

  assign q_push     = acc && done;
  assign q_desc     = '{length: hl, count: cnt + COUNT_W'(1), bank: bank};
  assign q_last_idx = (wp >= WPW'(FRAME_BYTES - 1)) ? AW'(FRAME_BYTES - 1) : wp[AW-1:0];

  always_comb begin
    busy_next = busy;
    if (bstat.clr) begin
      busy_next[bstat.clr_bank] = 1'b0;
    end
    if (q_push) begin
      busy_next[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pre   <= '0;
      second_pre  <= '0;
      first_post  <= '0;
      second_post <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_FIRST_PRE:   first_pre   <= cfg_data;
        REG_SECOND_PRE:  second_pre  <= cfg_data;
        REG_FIRST_POST:  first_post  <= cfg_data;
        REG_SECOND_POST: second_post <= cfg_data;
        default:         first_pre   <= first_pre;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PRE1;
      wp    <= '0;
      hl    <= '0;
      cnt   <= '0;
      bank  <= 1'b0;
      busy  <= 2'b00;
    end else begin
      busy <= busy_next;
      if (acc) begin
        phase <= phase_next;
        wp    <= wp_next;
        hl    <= hl_next;
        if (done) begin
          cnt  <= cnt + COUNT_W'(1);
          bank <= ~bank;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && st_en) begin
      prev <= b;
    end
  end

endmodule

// File: hw/rtl/plpd_back.sv
// ----------------------------------------------------------------------------
// plpd_back
// Frame reader: takes descriptors from the queue, reads the buffer bank
// byte by byte and drives the output stream through a register.
// ----------------------------------------------------------------------------
module plpd_back #(
  parameter int FRAME_BYTES = plpd_pkg::FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  plpd_pkg::frame_desc_t               q_desc,
  input  logic [$clog2(FRAME_BYTES)-1:0]      q_last_idx,
  output logic                                q_pop,
  output logic                                ram_re,
  output logic [$clog2(FRAME_BYTES):0]        ram_raddr,
  input  logic [plpd_pkg::BYTE_W-1:0]         ram_rdata,
  output plpd_pkg::back_stat_t                bstat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [plpd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast
);

  import plpd_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);

  logic               active;
  logic               bk;
  logic [AW-1:0]      k;
  logic [AW-1:0]      last_idx;
  logic [BYTE_W-1:0]  hl;
  logic [COUNT_W-1:0] fc;
  logic               rd_pend;
  logic               rd_last;
  logic [AW-1:0]      rd_idx;
  logic               issue;
  logic               at_end;
  logic [INDEX_W-1:0] idx6;

  assign issue  = active && !rd_pend && (!m_tvalid || m_tready);
  assign at_end = (k == last_idx);
  assign q_pop  = !active && !rd_pend && !q_empty;

  assign ram_re    = issue;
  assign ram_raddr = {bk, k};
  assign idx6      = INDEX_W'(rd_idx);

  assign bstat = '{clr: issue && at_end, clr_bank: bk, active: active};

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (issue && at_end) begin
        active <= 1'b0;
      end
      rd_pend <= issue;
      if (rd_pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bk       <= q_desc.bank;
      hl       <= q_desc.length;
      fc       <= q_desc.count;
      last_idx <= q_last_idx;
      k        <= '0;
    end else if (issue) begin
      k <= k + AW'(1);
    end
    if (issue) begin
      rd_idx  <= k;
      rd_last <= at_end;
    end
    if (rd_pend) begin
      m_tdata <= OUT_TDATA_W'({fc, hl, idx6, ram_rdata});
      m_tlast <= rd_last;
    end
  end

endmodule

// File: hw/rtl/preamble_length_postamble_deframer.sv
// ----------------------------------------------------------------------------
// preamble_length_postamble_deframer
// Finds preamble/length/postamble frames in a byte stream and replays each
// completed frame as a run of beats.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per beat; the parser takes a beat every
//   cycle while a buffer bank is free. Marker bytes are set on cfg_* while
//   the block is idle (index 0..3: first/second preamble, first/second
//   postamble).
//   m_* replays a completed frame from its buffer bank, one beat per stored
//   byte, tlast on the final one. The first beat follows the second postamble
//   beat through the descriptor queue, a RAM read and the output register;
//   the reader starts no new read while one is pending in its one-deep read pipeline.
//   Two banks of FRAME_BYTES bytes let the next frame be received while the
//   previous one is replayed. If both banks hold frames not yet fully read
//   out, s_tready drops until the reader issues the last read of one.
//   A stalled receiver holds the output beat and in turn stops the reader.
//   Reset clears the parser, frame counter and queue; the buffer needs no
//   clearing pass, so input is taken from the first cycle after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module preamble_length_postamble_deframer #(
  parameter int FRAME_BYTES = plpd_pkg::FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [plpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [plpd_pkg::BYTE_W-1:0]         cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] rx_byte
  input  logic [plpd_pkg::BYTE_W-1:0]         s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] frame_byte, [13:8] byte_index, [21:14] frame_length,
  // [37:22] frame_count, [39:38] zero
  output logic [plpd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast
);

  import plpd_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int QW = $bits(frame_desc_t) + AW;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [1:0]        q_count;
  frame_desc_t       w_desc;
  frame_desc_t       r_desc;
  logic [AW-1:0]     w_last_idx;
  logic [AW-1:0]     r_last_idx;
  logic              ram_we;
  logic [AW:0]       ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW:0]       ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  back_stat_t        bstat;
  logic [1:0]        busy;

  plpd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_desc     (w_desc),
    .q_last_idx (w_last_idx),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .bstat      (bstat),
    .busy       (busy)
  );

  plpd_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({w_desc, w_last_idx}),
    .pop   (q_pop),
    .rdata ({r_desc, r_last_idx}),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  plpd_ram #(.WIDTH(BYTE_W), .DEPTH(2 * (1 << AW))) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plpd_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_desc     (r_desc),
    .q_last_idx (r_last_idx),
    .q_pop      (q_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .bstat      (bstat),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  `ASSERT_IMPL(a_push_has_room, q_push, !q_full, "frame descriptor pushed into a full queue")
  `ASSERT_AT(a_bank_account, $countones(busy) == int'(q_count) + int'(bstat.active), "bank tally")
  `ASSERT_IMPL(a_bank_free_on_write, ram_we, !busy[ram_waddr[AW]], "write into a held bank")

endmodule
